### rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants, register indexes and segment tables for the
// marching-squares isoline segmenter.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int COORD_BITS  = 16;

	localparam int COL_BITS    = $clog2(MAX_COLUMNS);
	localparam int ROW_BITS    = $clog2(MAX_ROWS);

	localparam int VALUE_BITS  = 32;
	localparam int DIM_BITS    = 11;
	localparam int CELL_BITS   = 13;
	localparam int OUT_BITS    = 16;
	localparam int CASE_BITS   = 4;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_USE_FIRST    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLUMNS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_HEIGHT  = 3'd5;

	// edge midpoints
	localparam logic [1:0] PT_LEFT   = 2'd0;
	localparam logic [1:0] PT_RIGHT  = 2'd1;
	localparam logic [1:0] PT_TOP    = 2'd2;
	localparam logic [1:0] PT_BOTTOM = 2'd3;

	// segment kinds
	localparam logic [2:0] KIND_LB = 3'd0;
	localparam logic [2:0] KIND_BR = 3'd1;
	localparam logic [2:0] KIND_RT = 3'd2;
	localparam logic [2:0] KIND_LT = 3'd3;
	localparam logic [2:0] KIND_LR = 3'd4;
	localparam logic [2:0] KIND_TB = 3'd5;

	typedef struct packed {
		logic [1:0] count;
		logic [2:0] kind0;
		logic [2:0] kind1;
	} seg_plan_t;

	typedef struct packed {
		logic [1:0] start_pt;
		logic [1:0] end_pt;
	} seg_ends_t;

	function automatic seg_plan_t case_plan(input logic [CASE_BITS-1:0] cs);
		seg_plan_t p;
		p = '{count: 2'd1, kind0: KIND_LB, kind1: KIND_LB};
		case (cs)
			4'd0:  p.count = 2'd0;
			4'd1:  p.kind0 = KIND_LB;
			4'd2:  p.kind0 = KIND_BR;
			4'd3:  p.kind0 = KIND_LR;
			4'd4:  p.kind0 = KIND_RT;
			4'd5:  p = '{count: 2'd2, kind0: KIND_LT, kind1: KIND_BR};
			4'd6:  p.kind0 = KIND_TB;
			4'd7:  p.kind0 = KIND_LT;
			4'd8:  p.kind0 = KIND_LT;
			4'd9:  p.kind0 = KIND_TB;
			4'd10: p = '{count: 2'd2, kind0: KIND_LB, kind1: KIND_RT};
			4'd11: p.kind0 = KIND_RT;
			4'd12: p.kind0 = KIND_LR;
			4'd13: p.kind0 = KIND_BR;
			4'd14: p.kind0 = KIND_LB;
			default: p.count = 2'd0;
		endcase
		return p;
	endfunction

	function automatic seg_ends_t kind_ends(input logic [2:0] kind);
		seg_ends_t e;
		case (kind)
			KIND_LB: e = '{start_pt: PT_LEFT,   end_pt: PT_BOTTOM};
			KIND_BR: e = '{start_pt: PT_BOTTOM, end_pt: PT_RIGHT};
			KIND_RT: e = '{start_pt: PT_RIGHT,  end_pt: PT_TOP};
			KIND_LT: e = '{start_pt: PT_LEFT,   end_pt: PT_TOP};
			KIND_LR: e = '{start_pt: PT_LEFT,   end_pt: PT_RIGHT};
			KIND_TB: e = '{start_pt: PT_TOP,    end_pt: PT_BOTTOM};
			default: e = '{start_pt: PT_LEFT,   end_pt: PT_BOTTOM};
		endcase
		return e;
	endfunction

endpackage

### rtl/core/marching_squares_segmenter.sv
// Path: the first segment of a sample passes the stage-1, stage-2 and output
// registers after its request is accepted; a second segment follows it.
// Throughput: one sample per cycle while the output is not stalled; a saddle cell,
// which gives two segments, holds the segment stage until both have entered the output register.
// Reset: control state, counters and comparison history cleared, registers
// to defaults; line buffer contents undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// marching_squares_segmenter
// Streams grid samples, thresholds them, keeps their bits in a line buffer and emits the
// isoline segments of each closed 2x2 cell in image pixel coordinates.
// ----------------------------------------------------------------------------
module marching_squares_segmenter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mss_pkg::VALUE_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mss_pkg::VALUE_BITS-1:0] first_value,
	input  logic signed [mss_pkg::VALUE_BITS-1:0] second_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mss_pkg::OUT_BITS-1:0]        start_x,
	output logic [mss_pkg::OUT_BITS-1:0]        start_y,
	output logic [mss_pkg::OUT_BITS-1:0]        end_x,
	output logic [mss_pkg::OUT_BITS-1:0]        end_y,
	output logic [mss_pkg::CASE_BITS-1:0]       cell_case,
	output logic                                last_segment
);
	import mss_pkg::*;

	// configuration
	logic signed [VALUE_BITS-1:0] threshold_q;
	logic                         use_first_q;
	logic [DIM_BITS-1:0]          grid_columns_q;
	logic [DIM_BITS-1:0]          grid_rows_q;
	logic [CELL_BITS-1:0]         cell_width_q;
	logic [CELL_BITS-1:0]         cell_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= '0;
			use_first_q    <= 1'b1;
			grid_columns_q <= DIM_BITS'(2);
			grid_rows_q    <= DIM_BITS'(2);
			cell_width_q   <= CELL_BITS'(1);
			cell_height_q  <= CELL_BITS'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD:    threshold_q    <= cfg_data;
				REG_USE_FIRST:    use_first_q    <= cfg_data[0];
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[DIM_BITS-1:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[DIM_BITS-1:0];
				REG_CELL_WIDTH:   cell_width_q   <= cfg_data[CELL_BITS-1:0];
				REG_CELL_HEIGHT:  cell_height_q  <= cfg_data[CELL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size
	logic [COL_BITS:0] cols;
	logic [ROW_BITS:0] rows;

	always_comb begin
		if (grid_columns_q < DIM_BITS'(2))
			cols = (COL_BITS+1)'(2);
		else if (32'(grid_columns_q) > 32'(MAX_COLUMNS))
			cols = (COL_BITS+1)'(MAX_COLUMNS);
		else
			cols = (COL_BITS+1)'(grid_columns_q);
		if (grid_rows_q < DIM_BITS'(2))
			rows = (ROW_BITS+1)'(2);
		else if (32'(grid_rows_q) > 32'(MAX_ROWS))
			rows = (ROW_BITS+1)'(MAX_ROWS);
		else
			rows = (ROW_BITS+1)'(grid_rows_q);
	end

	// handshake and stage control
	logic valid_s1, valid_s2, out_valid_q;
	logic s1_free, s2_free, s2_done, out_free, load_out, accept, seg_last;

	// stage 0: compare, position
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                prev_q;
	logic                above_left_q;
	logic                cur;
	logic                emit;
	logic [COL_BITS:0]   col_inc;
	logic [ROW_BITS:0]   row_inc;
	logic [ROW_BITS:0]   row_flip;
	logic                below;

	assign cur = use_first_q ? (first_value >= threshold_q) : (second_value >= threshold_q);
	assign emit = (col_q != '0) && (row_q != '0) &&
	              ({1'b0, col_q} < cols) && ({1'b0, row_q} < rows);
	assign col_inc  = {1'b0, col_q} + (COL_BITS+1)'(1);
	assign row_inc  = {1'b0, row_q} + (ROW_BITS+1)'(1);
	assign row_flip = rows - (ROW_BITS+1)'(1) - {1'b0, row_q};

	assign in_ready = s1_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			prev_q <= 1'b0;
		end else if (accept) begin
			prev_q <= cur;
			if (col_inc >= cols) begin
				col_q <= '0;
				row_q <= (row_inc >= rows) ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	mss_line_buf u_line_buf (
		.clk    (clk),
		.en     (accept),
		.addr   (col_q),
		.wr_bit (cur),
		.rd_bit (below)
	);

	// stage 1
	logic                cur_s1, prev_s1, emit_s1;
	logic [COL_BITS-1:0] col_m1_s1;
	logic [ROW_BITS-1:0] row_flip_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur;
			prev_s1     <= prev_q;
			emit_s1     <= emit;
			col_m1_s1   <= col_q - COL_BITS'(1);
			row_flip_s1 <= row_flip[ROW_BITS-1:0];
		end
	end

	logic [CASE_BITS-1:0]          case_s1;
	seg_plan_t                     plan_s1;
	logic [CELL_BITS+COL_BITS-1:0] x_prod;
	logic [CELL_BITS+ROW_BITS-1:0] y_prod;

	assign case_s1 = {prev_s1, cur_s1, below, above_left_q};
	assign plan_s1 = case_plan(case_s1);
	assign x_prod  = (CELL_BITS+COL_BITS)'(cell_width_q) * (CELL_BITS+COL_BITS)'(col_m1_s1);
	assign y_prod  = (CELL_BITS+ROW_BITS)'(cell_height_q) * (CELL_BITS+ROW_BITS)'(row_flip_s1);

	assign s1_free = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			above_left_q <= 1'b0;
		else if (valid_s1 && s2_free)
			above_left_q <= below;
	end

	// stage 2: segment issue
	logic [CASE_BITS-1:0]  case_s2;
	logic [1:0]            count_s2;
	logic [2:0]            kind0_s2, kind1_s2;
	logic                  seg_s2;
	logic [COORD_BITS-1:0] x0_s2, y0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			seg_s2   <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
			seg_s2   <= 1'b0;
		end else if (load_out) begin
			seg_s2   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			case_s2  <= case_s1;
			count_s2 <= emit_s1 ? plan_s1.count : 2'd0;
			kind0_s2 <= plan_s1.kind0;
			kind1_s2 <= plan_s1.kind1;
			x0_s2    <= COORD_BITS'(x_prod);
			y0_s2    <= COORD_BITS'(y_prod);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign seg_last = seg_s2 || (count_s2 == 2'd1);
	assign load_out = valid_s2 && (count_s2 != 2'd0) && out_free;
	assign s2_done  = valid_s2 && ((count_s2 == 2'd0) || (out_free && seg_last));
	assign s2_free  = !valid_s2 || s2_done;

	seg_ends_t             ends;
	logic [COORD_BITS-1:0] w_full, w_half, h_full, h_half;
	logic [COORD_BITS-1:0] sx, sy, ex, ey;

	assign ends   = kind_ends(seg_s2 ? kind1_s2 : kind0_s2);
	assign w_full = COORD_BITS'(cell_width_q);
	assign w_half = COORD_BITS'(cell_width_q >> 1);
	assign h_full = COORD_BITS'(cell_height_q);
	assign h_half = COORD_BITS'(cell_height_q >> 1);

	always_comb begin
		case (ends.start_pt)
			PT_LEFT:  begin sx = x0_s2;          sy = y0_s2 + h_half; end
			PT_RIGHT: begin sx = x0_s2 + w_full; sy = y0_s2 + h_half; end
			PT_TOP:   begin sx = x0_s2 + w_half; sy = y0_s2;          end
			default:  begin sx = x0_s2 + w_half; sy = y0_s2 + h_full; end
		endcase
		case (ends.end_pt)
			PT_LEFT:  begin ex = x0_s2;          ey = y0_s2 + h_half; end
			PT_RIGHT: begin ex = x0_s2 + w_full; ey = y0_s2 + h_half; end
			PT_TOP:   begin ex = x0_s2 + w_half; ey = y0_s2;          end
			default:  begin ex = x0_s2 + w_half; ey = y0_s2 + h_full; end
		endcase
	end

	// output register
	logic [OUT_BITS-1:0]  start_x_q, start_y_q, end_x_q, end_y_q;
	logic [CASE_BITS-1:0] cell_case_q;
	logic                 last_segment_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= load_out;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			start_x_q      <= OUT_BITS'(sx);
			start_y_q      <= OUT_BITS'(sy);
			end_x_q        <= OUT_BITS'(ex);
			end_y_q        <= OUT_BITS'(ey);
			cell_case_q    <= case_s2;
			last_segment_q <= seg_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign start_x      = start_x_q;
	assign start_y      = start_y_q;
	assign end_x        = end_x_q;
	assign end_y        = end_y_q;
	assign cell_case    = cell_case_q;
	assign last_segment = last_segment_q;

endmodule

### rtl/core/mss_line_buf.sv
// ----------------------------------------------------------------------------
// mss_line_buf
// One-bit line buffer holding the previous row's comparison bits. Read-first
// synchronous RAM: the old bit comes out one cycle after the access while
// the new bit is written at the same address.
// ----------------------------------------------------------------------------
module mss_line_buf (
	input  logic                        clk,
	input  logic                        en,
	input  logic [mss_pkg::COL_BITS-1:0] addr,
	input  logic                        wr_bit,
	output logic                        rd_bit
);
	import mss_pkg::*;

	logic mem [MAX_COLUMNS];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wr_bit;
		end
	end

	assign rd_bit = rd_q;

endmodule

### tb/sv/tb_marching_squares_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marching_squares_segmenter
// Streams thresholded grid samples into the segmenter and predicts every
// isoline segment it should emit. The prediction tracks the line buffer, the
// position in the grid and the register settings. It is checked field by
// field against the output, under random bursts on the input side and stalls
// on the output side.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [15:0] end_x;
	logic [15:0] end_y;
	logic [3:0]  cell_case;
	logic        last_segment;
} segment_t;

typedef enum {SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_BOTTOM} side_e;

function automatic int clamp_grid(input logic [10:0] v, input int hi);
	if (v < 2)
		return 2;
	if (v > hi)
		return hi;
	return int'(v);
endfunction

class segment_scoreboard;
	logic [31:0] threshold;
	logic        use_first;
	logic [10:0] grid_columns;
	logic [10:0] grid_rows;
	logic [12:0] cell_width;
	logic [12:0] cell_height;

	bit          row_bits [mss_pkg::MAX_COLUMNS];
	bit          previous_bit;
	bit          above_left_bit;
	int          col_pos;
	int          row_pos;

	segment_t    segment_q [$];
	int          failures;

	function new();
		threshold      = '0;
		use_first      = 1'b1;
		grid_columns   = 11'd2;
		grid_rows      = 11'd2;
		cell_width     = 13'd1;
		cell_height    = 13'd1;
		previous_bit   = 1'b0;
		above_left_bit = 1'b0;
		col_pos        = 0;
		row_pos        = 0;
		failures       = 0;
		foreach (row_bits[i])
			row_bits[i] = 1'b0;
	endfunction

	function void write_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			mss_pkg::REG_THRESHOLD:    threshold    = data;
			mss_pkg::REG_USE_FIRST:    use_first    = data[0];
			mss_pkg::REG_GRID_COLUMNS: grid_columns = data[10:0];
			mss_pkg::REG_GRID_ROWS:    grid_rows    = data[10:0];
			mss_pkg::REG_CELL_WIDTH:   cell_width   = data[12:0];
			mss_pkg::REG_CELL_HEIGHT:  cell_height  = data[12:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return segment_q.size();
	endfunction

	// sides joined by each segment of a case, in output order
	function int case_sides(input logic [3:0] cs, output side_e s0, e0, s1, e1);
		s0 = SIDE_LEFT;
		e0 = SIDE_BOTTOM;
		s1 = SIDE_LEFT;
		e1 = SIDE_BOTTOM;
		case (cs)
			4'd1, 4'd14: return 1;
			4'd2, 4'd13: begin s0 = SIDE_BOTTOM; e0 = SIDE_RIGHT; return 1; end
			4'd3, 4'd12: begin e0 = SIDE_RIGHT; return 1; end
			4'd4, 4'd11: begin s0 = SIDE_RIGHT; e0 = SIDE_TOP; return 1; end
			4'd6, 4'd9:  begin s0 = SIDE_TOP; e0 = SIDE_BOTTOM; return 1; end
			4'd7, 4'd8:  begin e0 = SIDE_TOP; return 1; end
			4'd5: begin
				e0 = SIDE_TOP;
				s1 = SIDE_BOTTOM;
				e1 = SIDE_RIGHT;
				return 2;
			end
			4'd10: begin
				s1 = SIDE_RIGHT;
				e1 = SIDE_TOP;
				return 2;
			end
			default: return 0;
		endcase
	endfunction

	function void side_point(input side_e s, input longint unsigned x0, y0,
			output logic [15:0] px, py);
		longint unsigned w, h, x, y;
		w = cell_width;
		h = cell_height;
		case (s)
			SIDE_LEFT:  begin x = x0;         y = y0 + h / 2; end
			SIDE_RIGHT: begin x = x0 + w;     y = y0 + h / 2; end
			SIDE_TOP:   begin x = x0 + w / 2; y = y0;         end
			default:    begin x = x0 + w / 2; y = y0 + h;     end
		endcase
		px = 16'(x);
		py = 16'(y);
	endfunction

	function void note_sample(input logic [31:0] first, second);
		int               cols, rows, n;
		logic [31:0]      v;
		bit               now_bit, below;
		logic [3:0]       cs;
		longint unsigned  x0, y0;
		side_e            s [2];
		side_e            e [2];
		segment_t         seg;
		cols    = clamp_grid(grid_columns, mss_pkg::MAX_COLUMNS);
		rows    = clamp_grid(grid_rows, mss_pkg::MAX_ROWS);
		v       = use_first ? first : second;
		now_bit = $signed(v) >= $signed(threshold);
		below   = 1'b0;
		if (col_pos < mss_pkg::MAX_COLUMNS) begin
			below = row_bits[col_pos];
			row_bits[col_pos] = now_bit;
		end
		if (col_pos >= 1 && row_pos >= 1 && col_pos < cols && row_pos < rows) begin
			cs = {previous_bit, now_bit, below, above_left_bit};
			x0 = longint'(cell_width) * longint'(col_pos - 1);
			y0 = longint'(cell_height) * longint'(rows - 1 - row_pos);
			n  = case_sides(cs, s[0], e[0], s[1], e[1]);
			for (int k = 0; k < n; k++) begin
				side_point(s[k], x0, y0, seg.start_x, seg.start_y);
				side_point(e[k], x0, y0, seg.end_x, seg.end_y);
				seg.cell_case    = cs;
				seg.last_segment = (k == n - 1);
				segment_q.push_back(seg);
			end
		end
		above_left_bit = below;
		previous_bit   = now_bit;
		if (col_pos + 1 >= cols) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	function void compare_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	function void check_segment(input segment_t got);
		segment_t want;
		if (segment_q.size() == 0) begin
			$error("segment with none outstanding: case %0d", got.cell_case);
			failures++;
			return;
		end
		want = segment_q.pop_front();
		compare_field("start_x", want.start_x, got.start_x);
		compare_field("start_y", want.start_y, got.start_y);
		compare_field("end_x", want.end_x, got.end_x);
		compare_field("end_y", want.end_y, got.end_y);
		compare_field("cell_case", 16'(want.cell_case), 16'(got.cell_case));
		compare_field("last_segment", 16'(want.last_segment), 16'(got.last_segment));
	endfunction
endclass

module tb_marching_squares_segmenter;
	import mss_pkg::*;

	localparam int     RANDOM_ITEMS = 290;
	localparam int     SETTLE_CYCLES = 10;
	localparam int     DRAIN_LIMIT = 20000;
	localparam longint TIMEOUT_NS = 5_000_000;
	localparam longint LEVEL_MIN = -64'sd2147483648;
	localparam longint LEVEL_MAX = 64'sd2147483647;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [VALUE_BITS-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] first_value;
	logic [VALUE_BITS-1:0] second_value;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_BITS-1:0]   start_x;
	logic [OUT_BITS-1:0]   start_y;
	logic [OUT_BITS-1:0]   end_x;
	logic [OUT_BITS-1:0]   end_y;
	logic [CASE_BITS-1:0]  cell_case;
	logic                  last_segment;

	segment_scoreboard     sb;
	bit                    level_plan [$];
	int                    burst_left = 0;
	ready_mode_e           ready_mode = READY_ALWAYS;
	int unsigned           ready_cycle = 0;

	marching_squares_segmenter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.cell_case    (cell_case),
		.last_segment (last_segment)
	);

	always #2 clk = ~clk;

	// receiver: switches at random between always ready, random stalls and a fixed ready pattern
	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		if (ready_cycle[6:0] == 0)
			ready_mode <= ready_mode_e'($urandom_range(0, 2));
		case (ready_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default:      out_ready <= ((ready_cycle % 23) < 9);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready)
				sb.note_sample(first_value, second_value);
			if (out_valid && out_ready)
				sb.check_segment('{start_x, start_y, end_x, end_y, cell_case, last_segment});
		end
	end

	// value on the requested side of the threshold
	function automatic logic [31:0] level_value(input bit want, input logic [31:0] thr);
		longint          lo, hi;
		longint unsigned span;
		lo = want ? longint'($signed(thr)) : LEVEL_MIN;
		hi = want ? LEVEL_MAX : longint'($signed(thr)) - 1;
		if (hi < lo)
			return thr;
		case ($urandom_range(0, 3))
			0: return want ? thr : thr - 1;
			1: return want ? 32'h7fff_ffff : 32'h8000_0000;
			default: begin
				span = hi - lo + 1;
				return 32'(lo + longint'({$urandom(), $urandom()} % span));
			end
		endcase
	endfunction

	function automatic int samples_to_origin(input int c, r, cols, rows);
		int count;
		count = 0;
		do begin
			if (c + 1 >= cols) begin
				c = 0;
				r = (r + 1 >= rows) ? 0 : r + 1;
			end else begin
				c++;
			end
			count++;
		end while (c != 0 || r != 0);
		return count;
	endfunction

	function automatic logic [31:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [12:0] pick_cell();
		case ($urandom_range(0, 7))
			0: return 13'd0;
			1: return 13'd8191;
			2: return 13'd4096;
			3: return 13'($urandom_range(0, 8191));
			default: return 13'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic wait_idle();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] thr, input logic uf,
			input logic [10:0] cols, rows, input logic [12:0] cw, ch);
		logic [2:0]  idx [6];
		logic [31:0] val [6];
		idx = '{REG_THRESHOLD, REG_USE_FIRST, REG_GRID_COLUMNS,
			REG_GRID_ROWS, REG_CELL_WIDTH, REG_CELL_HEIGHT};
		// unused upper bits carry noise
		val = '{thr,
			($urandom() & ~32'h1) | 32'(uf),
			($urandom() & ~32'h7ff) | 32'(cols),
			($urandom() & ~32'h7ff) | 32'(rows),
			($urandom() & ~32'h1fff) | 32'(cw),
			($urandom() & ~32'h1fff) | 32'(ch)};
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_write <= 1'b0;
	endtask

	task automatic send_samples(input int count);
		bit          want;
		int          gap;
		logic [31:0] picked, other;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 32);
			end
			want   = (level_plan.size() != 0) ? level_plan.pop_front() : 1'($urandom_range(0, 1));
			picked = level_value(want, sb.threshold);
			other  = $urandom();
			in_valid     <= 1'b1;
			first_value  <= sb.use_first ? picked : other;
			second_value <= sb.use_first ? other : picked;
			do @(posedge clk); while (in_ready !== 1'b1);
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] thr, input logic uf,
			input logic [10:0] cols, rows, input logic [12:0] cw, ch, input int count);
		wait_idle();
		configure(thr, uf, cols, rows, cw, ch);
		send_samples(count);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		// pair of levels per column walks every transition, so each case appears once
		int          pairs [17];
		int          sent, n, to_end, cols_e, rows_e;
		logic [10:0] cols, rows;
		int          guard;

		pairs        = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
		sb           = new();
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		first_value  = '0;
		second_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pairs[c])
			level_plan.push_back(pairs[c][0]);
		foreach (pairs[c])
			level_plan.push_back(pairs[c][1]);
		run_phase(32'h0, 1'b1, 11'd17, 11'd2, 13'd6, 13'd9, 34);

		// widest grid with clamped sizes, part of the first row only
		run_phase(32'h0001_8000, 1'b0, 11'd2047, 11'd1, 13'd8191, 13'd4096, 60);
		// tallest grid, stopped part way down
		run_phase($urandom(), 1'b1, 11'd2, 11'd2047, 13'd0, 13'd8191, 40);
		// rows shrunk below the current position
		run_phase($urandom(), 1'b0, 11'd1, 11'd3, 13'd1, 13'd1, 30);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			cols = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1))
				: 11'($urandom_range(2, 12));
			case ($urandom_range(0, 9))
				0: rows = 11'($urandom_range(0, 1));
				1: rows = 11'($urandom_range(1024, 2047));
				default: rows = 11'($urandom_range(2, 8));
			endcase
			// widening is only safe at the top of a frame, where no cell is read back
			if (clamp_grid(cols, MAX_COLUMNS) > clamp_grid(sb.grid_columns, MAX_COLUMNS)
					&& (sb.col_pos != 0 || sb.row_pos != 0))
				cols = sb.grid_columns;
			cols_e = clamp_grid(cols, MAX_COLUMNS);
			rows_e = clamp_grid(rows, MAX_ROWS);
			to_end = samples_to_origin(sb.col_pos, sb.row_pos, cols_e, rows_e);
			if (to_end <= 120 && $urandom_range(0, 3) != 0)
				n = to_end + ((cols_e * rows_e <= 120) ? cols_e * rows_e * $urandom_range(0, 1) : 0);
			else
				n = $urandom_range(1, 40);
			run_phase(pick_threshold(), 1'($urandom_range(0, 1)), cols, rows,
				pick_cell(), pick_cell(), n);
			sent += n;
		end

		guard = 0;
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d segments never arrived", sb.pending());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/mss_pkg.sv
rtl/core/mss_line_buf.sv
rtl/core/marching_squares_segmenter.sv
tb/sv/tb_marching_squares_segmenter.sv
